/* sv/hfcc_pkg.sv */
// Package for the humidity frame CRC/convert block: status codes, CRC-8 step
// and the scaling constants. No dependencies.
package hfcc_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_CRC  = 2'd1,
		STAT_COMM = 2'd2
	} status_t;

	// Frame layout: byte positions
	localparam logic [2:0] IDX_T_HI  = 3'd0;
	localparam logic [2:0] IDX_T_LO  = 3'd1;
	localparam logic [2:0] IDX_T_CRC = 3'd2;
	localparam logic [2:0] IDX_H_HI  = 3'd3;
	localparam logic [2:0] IDX_H_LO  = 3'd4;
	localparam logic [2:0] IDX_H_CRC = 3'd5;

	// CRC-8, x^8+x^5+x^4+1, init 0xFF, MSB first
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// Scaling
	localparam logic [14:0] TEMP_SPAN   = 15'd17500;
	localparam logic [13:0] HUMID_SPAN  = 14'd10000;
	localparam logic [14:0] TEMP_OFFSET = 15'd4500;
	localparam logic [16:0] FULL_SCALE  = 17'd65535;

	// Width of the scaled products
	localparam int TPROD_W = 31;
	localparam int HPROD_W = 30;

	// One CRC byte update, eight shift steps on an 8-bit value
	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* sv/humidity_frame_crc_convert_top.sv */
// Humidity/temperature reply frame checker and converter, top level.
// Depends on hfcc_pkg (status codes, CRC step, scaling constants).
//
// The block takes one reply byte per input beat, one beat per cycle while in_ready
// is high: temperature word (big-endian), its CRC-8, humidity word, its CRC-8. The
// sixth byte, or any beat with addr_nak set, produces one result beat once through
// the stages below: status and the converted values in hundredths, zero unless status
// is OK. Other bytes produce no result. Three registered stages follow the frame
// state: captured words, constant products, then the divide by 65535 (one
// correction step) and the offset. Each stage has its own ready, so bubbles are
// squeezed out and input keeps flowing while a result waits at the output.
module humidity_frame_crc_convert_top
	import hfcc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	input  logic               addr_nak,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]        humidity_centi
);

	// Frame state
	logic [2:0]  byte_index_q;
	logic [7:0]  running_crc_q;
	logic [15:0] temp_word_q;
	logic [15:0] humid_word_q;
	logic        crc_failed_q;

	// Pipeline
	logic                 v_s1, v_s2, v_s3;
	logic                 rdy_s1, rdy_s2, rdy_s3;
	status_t              stat_s1, stat_s2, stat_s3;
	logic [15:0]          tword_s1, hword_s1;
	logic [TPROD_W-1:0]   tprod_s2;
	logic [HPROD_W-1:0]   hprod_s2;
	logic signed [14:0]   temp_s3;
	logic [13:0]          humid_s3;

	logic       in_fire;
	logic [2:0] idx;
	logic       emit;
	logic       crc_bad;
	logic [7:0] crc_next;

	// Per-stage ready
	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign in_fire  = in_valid && in_ready;

	// Out-of-range index restarts the frame
	assign idx      = (byte_index_q > IDX_H_CRC) ? IDX_T_HI : byte_index_q;
	assign crc_next = crc8_feed(running_crc_q, rx_byte);
	assign crc_bad  = crc_failed_q || (running_crc_q != rx_byte);
	assign emit     = addr_nak || (idx == IDX_H_CRC);

	// Frame state update per accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q  <= IDX_T_HI;
			running_crc_q <= CRC_INIT;
			temp_word_q   <= '0;
			humid_word_q  <= '0;
			crc_failed_q  <= 1'b0;
		end else if (in_fire) begin
			if (addr_nak || idx == IDX_H_CRC) begin
				if (!addr_nak) begin
					humid_word_q <= humid_word_q;
				end
				byte_index_q  <= IDX_T_HI;
				running_crc_q <= CRC_INIT;
				crc_failed_q  <= 1'b0;
			end else begin
				byte_index_q <= idx + 3'd1;
				case (idx)
					IDX_T_HI: begin
						temp_word_q[15:8] <= rx_byte;
						running_crc_q     <= crc_next;
					end
					IDX_T_LO: begin
						temp_word_q[7:0] <= rx_byte;
						running_crc_q    <= crc_next;
					end
					IDX_H_HI: begin
						humid_word_q[15:8] <= rx_byte;
						running_crc_q      <= crc_next;
					end
					IDX_H_LO: begin
						humid_word_q[7:0] <= rx_byte;
						running_crc_q     <= crc_next;
					end
					default: begin
						// temperature check byte
						crc_failed_q  <= crc_bad;
						running_crc_q <= CRC_INIT;
					end
				endcase
			end
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_fire && emit;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// s1: final status and raw words
	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			if (addr_nak) begin
				stat_s1 <= STAT_COMM;
			end else if (crc_bad) begin
				stat_s1 <= STAT_CRC;
			end else begin
				stat_s1 <= STAT_OK;
			end
			tword_s1 <= temp_word_q;
			hword_s1 <= humid_word_q;
		end
	end

	// s2: constant products, operands widened to the product width
	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			stat_s2  <= stat_s1;
			tprod_s2 <= TPROD_W'(TEMP_SPAN) * TPROD_W'(tword_s1);
			hprod_s2 <= HPROD_W'(HUMID_SPAN) * HPROD_W'(hword_s1);
		end
	end

	// s3: divide by 65535 as x = q*65536 + low = q*65535 + (q + low),
	// one correction since q + low < 2*65535
	logic [14:0] tq0;
	logic [13:0] hq0;
	logic [16:0] trem, hrem;
	logic [14:0] tq;
	logic [13:0] hq;

	assign tq0  = tprod_s2[TPROD_W-1:16];
	assign hq0  = hprod_s2[HPROD_W-1:16];
	assign trem = {1'b0, tprod_s2[15:0]} + {2'b0, tq0};
	assign hrem = {1'b0, hprod_s2[15:0]} + {3'b0, hq0};
	assign tq   = tq0 + ((trem >= FULL_SCALE) ? 15'd1 : 15'd0);
	assign hq   = hq0 + ((hrem >= FULL_SCALE) ? 14'd1 : 14'd0);

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			stat_s3 <= stat_s2;
			if (stat_s2 == STAT_OK) begin
				temp_s3  <= $signed(tq - TEMP_OFFSET);
				humid_s3 <= hq;
			end else begin
				temp_s3  <= '0;
				humid_s3 <= '0;
			end
		end
	end

	// Result beat
	assign out_valid         = v_s3;
	assign status            = stat_s3;
	assign temperature_centi = temp_s3;
	assign humidity_centi    = humid_s3;

	// Checks
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_index_q <= IDX_H_CRC)
		else $error("byte index out of frame range");

	a_nak_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && addr_nak) |=> (byte_index_q == IDX_T_HI && running_crc_q == CRC_INIT
			&& !crc_failed_q))
		else $error("abort did not restart frame");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stat_s3 != STAT_OK) |-> (temperature_centi == 0 && humidity_centi == 0))
		else $error("values not zeroed on failed frame");

	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stat_s3 == STAT_OK) |-> (humidity_centi <= 14'd10000
			&& temperature_centi >= -15'sd4500 && temperature_centi <= 15'sd13000))
		else $error("converted value out of range");

	a_nak_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && addr_nak) |=> (v_s1 && stat_s1 == STAT_COMM))
		else $error("abort did not launch a failure result");

endmodule

/* tb/humidity_frame_crc_convert_top_test.sv */
// Testbench for humidity_frame_crc_convert_top: sends sensor reply bytes one beat
// at a time, tracks each frame locally and checks every result beat.
// Depends on hfcc_pkg and the RTL top level.
module humidity_frame_crc_convert_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hfcc_pkg::*;

	localparam int         ITEMS_TOTAL  = 1650;
	localparam int         PHASE_ITEMS  = 550;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         DRAIN_CYCLES = 20;
	localparam logic [7:0] POLY_LOW     = 8'h31;
	localparam logic [7:0] CRC_SEED     = 8'hFF;

	// One result beat
	typedef struct packed {
		status_t     st;
		logic [14:0] temp;
		logic [13:0] hum;
	} reading_t;

	// One row of the directed table
	typedef struct {
		logic [7:0] data;
		logic       nak;
		bit         given;
		reading_t   want;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic               addr_nak;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic signed [14:0] temperature_centi;
	logic [13:0]        humidity_centi;

	int send_idle_pct = 34;
	int recv_idle_pct = 67;
	int beats_sent    = 0;
	int fails         = 0;
	int cycles        = 0;

	reading_t pending_readings[$];
	row_t     directed_rows[$];
	reading_t head;

	// Local frame tracker state
	logic [2:0]  frame_pos = IDX_T_HI;
	logic [7:0]  crc_acc   = CRC_SEED;
	logic [15:0] t_raw     = '0;
	logic [15:0] h_raw     = '0;
	logic        crc_bad   = 1'b0;

	always #10 clk = ~clk;

	humidity_frame_crc_convert_top u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.rx_byte           (rx_byte),
		.addr_nak          (addr_nak),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi)
	);

	// CRC-8 update, data bit folded into the feedback each shift
	function automatic logic [7:0] crc_update(input logic [7:0] acc, input logic [7:0] data);
		logic [7:0] c;
		logic       fb;
		c = acc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ data[i];
			c  = {c[6:0], 1'b0} ^ (fb ? POLY_LOW : 8'h00);
		end
		return c;
	endfunction

	// Raw words to hundredths
	function automatic reading_t convert_words(input logic [15:0] tw, input logic [15:0] hw);
		reading_t    r;
		int unsigned tq;
		int unsigned hq;
		tq     = 17500 * tw;
		tq     = tq / 65535;
		hq     = 10000 * hw;
		hq     = hq / 65535;
		r.st   = STAT_OK;
		r.temp = 15'(tq - 32'd4500);
		r.hum  = hq[13:0];
		return r;
	endfunction

	// Advance the frame tracker by one accepted beat
	task automatic frame_track(input logic [7:0] data, input logic nak,
			output bit made, output reading_t r);
		made = 1'b0;
		r    = '{st: STAT_COMM, temp: '0, hum: '0};
		if (nak) begin
			made = 1'b1;
		end else begin
			if (frame_pos > IDX_H_CRC) begin
				frame_pos = IDX_T_HI;
			end
			case (frame_pos)
				IDX_T_HI: begin
					t_raw[15:8] = data;
					crc_acc     = crc_update(crc_acc, data);
				end
				IDX_T_LO: begin
					t_raw[7:0] = data;
					crc_acc    = crc_update(crc_acc, data);
				end
				IDX_H_HI: begin
					h_raw[15:8] = data;
					crc_acc     = crc_update(crc_acc, data);
				end
				IDX_H_LO: begin
					h_raw[7:0] = data;
					crc_acc    = crc_update(crc_acc, data);
				end
				default: begin
					// check byte of either word
					if (crc_acc != data) begin
						crc_bad = 1'b1;
					end
					crc_acc = CRC_SEED;
				end
			endcase
			if (frame_pos != IDX_H_CRC) begin
				frame_pos = frame_pos + 3'd1;
			end else begin
				made = 1'b1;
				if (crc_bad) begin
					r = '{st: STAT_CRC, temp: '0, hum: '0};
				end else begin
					r = convert_words(t_raw, h_raw);
				end
			end
		end
		// a result closes the frame; raw words are kept
		if (made) begin
			frame_pos = IDX_T_HI;
			crc_acc   = CRC_SEED;
			crc_bad   = 1'b0;
		end
	endtask

	// Drive one input beat, wait for it to be taken, then predict
	task automatic push_byte(input logic [7:0] data, input logic nak,
			input bit given, input reading_t want);
		bit       made;
		reading_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= data;
		addr_nak <= nak;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
		frame_track(data, nak, made, r);
		if (made) begin
			pending_readings.push_back(given ? want : r);
		end
	endtask

	task automatic add_row(input logic [7:0] data, input logic nak, input bit given,
			input status_t st, input int temp, input int hum);
		row_t row;
		row.data      = data;
		row.nak       = nak;
		row.given     = given;
		row.want.st   = st;
		row.want.temp = temp[14:0];
		row.want.hum  = hum[13:0];
		directed_rows.push_back(row);
	endtask

	// Well-formed frame with random words; some get a bad check byte or a NAK
	task automatic send_frame();
		logic [15:0] tw;
		logic [15:0] hw;
		logic [7:0]  fb [6];
		int          sel;
		int          nak_at;
		bit          aborted;
		sel     = $urandom_range(99);
		tw      = 16'($urandom);
		hw      = 16'($urandom);
		nak_at  = 6;
		aborted = 1'b0;
		if ($urandom_range(9) == 0) begin
			tw = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		end
		if ($urandom_range(9) == 0) begin
			hw = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		end
		fb[0] = tw[15:8];
		fb[1] = tw[7:0];
		fb[2] = crc_update(crc_update(CRC_SEED, fb[0]), fb[1]);
		fb[3] = hw[15:8];
		fb[4] = hw[7:0];
		fb[5] = crc_update(crc_update(CRC_SEED, fb[3]), fb[4]);
		if (sel < 10) begin
			fb[2] = fb[2] ^ (8'h01 << $urandom_range(7));
		end else if (sel < 20) begin
			fb[5] = fb[5] ^ (8'h01 << $urandom_range(7));
		end else if (sel < 30) begin
			nak_at = $urandom_range(5);
		end
		for (int i = 0; i < 6 && !aborted; i++) begin
			if (i == nak_at) begin
				push_byte(8'($urandom), 1'b1, 1'b0, '0);
				aborted = 1'b1;
			end else begin
				push_byte(fb[i], 1'b0, 1'b0, '0);
			end
		end
	endtask

	// Random bytes and NAKs, then random fill up to the end of the frame
	task automatic send_noise();
		int n;
		n = $urandom_range(5, 1);
		repeat (n) begin
			push_byte(8'($urandom), ($urandom_range(4) == 0), 1'b0, '0);
		end
		while (frame_pos != IDX_T_HI) begin
			push_byte(8'($urandom), 1'b0, 1'b0, '0);
		end
	endtask

	task automatic random_until(input int limit);
		while (beats_sent < limit) begin
			if ($urandom_range(3) != 0) begin
				send_frame();
			end else begin
				send_noise();
			end
		end
	endtask

	// Receiver side stalls
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected result beat: status %0d temp %0d hum %0d",
					$realtime, status, temperature_centi, humidity_centi);
				fails++;
			end else begin
				head = pending_readings.pop_front();
				if (status !== head.st) begin
					$display("%0t: status expected %0d actual %0d",
						$realtime, head.st, status);
					fails++;
				end
				if (temperature_centi !== head.temp) begin
					$display("%0t: temperature_centi expected %0d actual %0d",
						$realtime, $signed(head.temp), temperature_centi);
					fails++;
				end
				if (humidity_centi !== head.hum) begin
					$display("%0t: humidity_centi expected %0d actual %0d",
						$realtime, head.hum, humidity_centi);
					fails++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stimulus
	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		rx_byte   <= 8'h00;
		addr_nak  <= 1'b0;
		out_ready <= 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// NAK straight after reset
		add_row(8'hA5, 1'b1, 1'b1, STAT_COMM, 0, 0);
		// all-zero words: lowest temperature and humidity
		add_row(8'h00, 1'b0, 1'b0, STAT_OK, 0, 0);
		add_row(8'h00, 1'b0, 1'b0, STAT_OK, 0, 0);
		add_row(8'h81, 1'b0, 1'b0, STAT_OK, 0, 0);
		add_row(8'h00, 1'b0, 1'b0, STAT_OK, 0, 0);
		add_row(8'h00, 1'b0, 1'b0, STAT_OK, 0, 0);
		add_row(8'h81, 1'b0, 1'b1, STAT_OK, -4500, 0);
		// all-ones words: top of both scales
		add_row(8'hFF, 1'b0, 1'b0, STAT_OK, 0, 0);
		add_row(8'hFF, 1'b0, 1'b0, STAT_OK, 0, 0);
		add_row(8'hAC, 1'b0, 1'b0, STAT_OK, 0, 0);
		add_row(8'hFF, 1'b0, 1'b0, STAT_OK, 0, 0);
		add_row(8'hFF, 1'b0, 1'b0, STAT_OK, 0, 0);
		add_row(8'hAC, 1'b0, 1'b1, STAT_OK, 13000, 10000);
		// bad temperature check byte, good humidity word: frame still runs out
		add_row(8'hBE, 1'b0, 1'b0, STAT_OK, 0, 0);
		add_row(8'hEF, 1'b0, 1'b0, STAT_OK, 0, 0);
		add_row(8'h00, 1'b0, 1'b0, STAT_OK, 0, 0);
		add_row(8'h00, 1'b0, 1'b0, STAT_OK, 0, 0);
		add_row(8'h00, 1'b0, 1'b0, STAT_OK, 0, 0);
		add_row(8'h81, 1'b0, 1'b1, STAT_CRC, 0, 0);
		// NAK in the middle of a frame, data byte ignored
		add_row(8'h12, 1'b0, 1'b0, STAT_OK, 0, 0);
		add_row(8'h34, 1'b0, 1'b0, STAT_OK, 0, 0);
		add_row(8'hFF, 1'b1, 1'b1, STAT_COMM, 0, 0);

		foreach (directed_rows[i]) begin
			push_byte(directed_rows[i].data, directed_rows[i].nak,
				directed_rows[i].given, directed_rows[i].want);
		end

		// sender light idling, receiver heavy
		random_until(PHASE_ITEMS);

		// hold the sender off until the pipeline has drained
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);

		// sender heavy, receiver light
		send_idle_pct = 67;
		recv_idle_pct = 34;
		random_until(2 * PHASE_ITEMS);

		// back to back
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_until(ITEMS_TOTAL);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
